/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/hcbp_pkg.sv */
// ---------------------------------------------------------------------------
// hcbp_pkg
// Shared widths, defaults and codes of the Huffman code bit packer.
// ---------------------------------------------------------------------------
package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int BLOCK_BITS_DEF   = 320;

    localparam int MODE_W      = 2;
    localparam int SYM_W       = 8;
    localparam int LEN_IN_W    = 6;
    localparam int CODE_BITS_W = 32;
    localparam int BYTE_W      = 8;
    localparam int NUM_SYMS    = 256;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

endpackage

/* rtl/huffman_code_bit_packer_core.sv */
// ---------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Huffman encoder with an LSB-first byte packer and ASCII stream trailer.
//
//   channel  dir  handshake           payload
//   input    in   i_valid / o_stall   i_mode i_symbol i_code_length i_code_bits
//   output   out  o_valid / i_stall   o_out_byte o_last
//
// Load and unused-mode words emit no bytes. An encode word emits its packed bytes;
// a finish word with a nonzero block position emits its k leftover bits as ASCII
// digits, then k itself. The byte engine emits one byte per cycle while not stalled.
// A word goes through the read stage, the byte engine and the output register in turn.
// Reset clears all table entries at once (per-entry valid flops), no sweep.
// A stalled output holds its byte; while the engine has bytes left, the next word waits in the read stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_code_bit_packer_core #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int BLOCK_BITS   = hcbp_pkg::BLOCK_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [hcbp_pkg::MODE_W-1:0]        i_mode,
    input  logic [hcbp_pkg::SYM_W-1:0]         i_symbol,
    input  logic [hcbp_pkg::LEN_IN_W-1:0]      i_code_length,
    input  logic [hcbp_pkg::CODE_BITS_W-1:0]   i_code_bits,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [hcbp_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_last
);

    localparam int BITS_W = (MAX_CODE_LEN < hcbp_pkg::CODE_BITS_W) ?
                            MAX_CODE_LEN : hcbp_pkg::CODE_BITS_W;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int TAB_W  = LEN_W + BITS_W;
    localparam int ACC_W  = BITS_W + 7;
    localparam int TOT_W  = $clog2(MAX_CODE_LEN + 8);
    localparam int POS_W  = $clog2(BLOCK_BITS);

    // input acceptance and table write
    logic                               in_acc;
    logic [hcbp_pkg::LEN_IN_W-1:0]      len_sat;
    logic [BITS_W-1:0]                  wbits;
    logic [TAB_W-1:0]                   ram_rdata;
    logic [hcbp_pkg::NUM_SYMS-1:0]      r_tab_vld;

    // read stage
    logic                               r_s1_vld;
    logic                               r_s1_ent;
    logic [hcbp_pkg::MODE_W-1:0]        r_s1_mode;
    logic                               s1_adv;
    logic [LEN_W-1:0]                   s1_len;
    logic [BITS_W-1:0]                  s1_bits;

    // byte engine
    logic [ACC_W-1:0]                   r_acc, n_acc, b_acc;
    logic [TOT_W-1:0]                   r_tot, n_tot, b_tot;
    logic                               r_fin, n_fin, b_fin;
    logic [2:0]                         r_fcnt, n_fcnt;
    logic [POS_W-1:0]                   r_pos, n_pos;
    logic [POS_W:0]                     pos_sum;
    logic                               busy;
    logic                               emit;
    logic                               emit_last;
    logic [hcbp_pkg::BYTE_W-1:0]        emit_byte;

    // output register
    logic                               r_o_vld, n_o_vld;
    logic [hcbp_pkg::BYTE_W-1:0]        r_o_byte;
    logic                               r_o_last;

    assign in_acc = i_valid & ~o_stall;

    assign len_sat = (i_code_length > hcbp_pkg::LEN_IN_W'(MAX_CODE_LEN)) ?
                     hcbp_pkg::LEN_IN_W'(MAX_CODE_LEN) : i_code_length;

    always_comb begin
        for (int i = 0; i < BITS_W; i++) begin
            wbits[i] = i_code_bits[i] & (hcbp_pkg::LEN_IN_W'(i) < len_sat);
        end
    end

    hcbp_ram #(
        .WIDTH (TAB_W),
        .DEPTH (hcbp_pkg::NUM_SYMS)
    ) u_code_tab (
        .i_clk   (i_clk),
        .i_we    (in_acc & (i_mode == hcbp_pkg::MODE_LOAD)),
        .i_waddr (i_symbol),
        .i_wdata ({len_sat[LEN_W-1:0], wbits}),
        .i_re    (in_acc),
        .i_raddr (i_symbol),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld <= '0;
        end else if (in_acc && (i_mode == hcbp_pkg::MODE_LOAD)) begin
            r_tab_vld[i_symbol] <= 1'b1;
        end
    end

    // engine
    assign busy      = r_fin | ((r_tot >> 3) != '0);
    assign emit      = busy & (~r_o_vld | ~i_stall);
    assign emit_last = r_fin ? (r_tot == '0) : ((r_tot >> 3) == TOT_W'(1));
    assign s1_adv    = r_s1_vld & (~busy | (emit & emit_last));
    assign o_stall   = r_s1_vld & ~s1_adv;

    assign s1_len  = r_s1_ent ? ram_rdata[TAB_W-1:BITS_W] : '0;
    assign s1_bits = r_s1_ent ? ram_rdata[BITS_W-1:0] : '0;
    assign pos_sum = {1'b0, r_pos} + (POS_W+1)'(s1_len);

    always_comb begin
        emit_byte = r_acc[7:0];
        b_acc     = r_acc;
        b_tot     = r_tot;
        b_fin     = r_fin;
        if (emit) begin
            if (r_fin) begin
                if (r_tot != '0) begin
                    emit_byte = hcbp_pkg::ASCII_ZERO | {7'b0, r_acc[0]};
                    b_acc     = r_acc >> 1;
                    b_tot     = r_tot - TOT_W'(1);
                end else begin
                    emit_byte = hcbp_pkg::ASCII_ZERO | {5'b0, r_fcnt};
                    b_acc     = '0;
                    b_fin     = 1'b0;
                end
            end else begin
                b_acc = r_acc >> 8;
                b_tot = r_tot - TOT_W'(8);
            end
        end
    end

    always_comb begin
        n_acc  = b_acc;
        n_tot  = b_tot;
        n_fin  = b_fin;
        n_fcnt = r_fcnt;
        n_pos  = r_pos;
        if (s1_adv) begin
            unique case (r_s1_mode)
                hcbp_pkg::MODE_ENCODE: begin
                    n_acc = ACC_W'(b_acc[6:0]) | (ACC_W'(s1_bits) << b_tot[2:0]);
                    n_tot = TOT_W'(b_tot[2:0]) + TOT_W'(s1_len);
                    if (pos_sum >= (POS_W+1)'(BLOCK_BITS)) begin
                        n_pos = POS_W'(pos_sum - (POS_W+1)'(BLOCK_BITS));
                    end else begin
                        n_pos = pos_sum[POS_W-1:0];
                    end
                end
                hcbp_pkg::MODE_FINISH: begin
                    n_pos = '0;
                    if (r_pos != '0) begin
                        n_acc  = ACC_W'(b_acc[6:0]);
                        n_tot  = TOT_W'(b_tot[2:0]);
                        n_fcnt = b_tot[2:0];
                        n_fin  = 1'b1;
                    end else begin
                        n_acc = '0;
                        n_tot = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign n_o_vld = emit | (r_o_vld & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_acc    <= '0;
            r_tot    <= '0;
            r_fin    <= 1'b0;
            r_fcnt   <= '0;
            r_pos    <= '0;
            r_o_vld  <= 1'b0;
        end else begin
            r_s1_vld <= in_acc | (r_s1_vld & ~s1_adv);
            r_acc    <= n_acc;
            r_tot    <= n_tot;
            r_fin    <= n_fin;
            r_fcnt   <= n_fcnt;
            r_pos    <= n_pos;
            r_o_vld  <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode <= i_mode;
            r_s1_ent  <= r_tab_vld[i_symbol];
        end
        if (emit) begin
            r_o_byte <= emit_byte;
            r_o_last <= emit_last;
        end
    end

    assign o_valid    = r_o_vld;
    assign o_out_byte = r_o_byte;
    assign o_last     = r_o_last;

    `ASSERT_CLK(a_pos_range, i_clk, i_rst_n, ({1'b0, r_pos} < (POS_W+1)'(BLOCK_BITS)), "block position out of range")
    `ASSERT_CLK(a_fin_clears_pos, i_clk, i_rst_n, (s1_adv && (r_s1_mode == hcbp_pkg::MODE_FINISH)) |=> (r_pos == '0), "finish left block position set")
    `ASSERT_CLK(a_fin_count, i_clk, i_rst_n, r_fin |-> ((r_tot >> 3) == '0) && (r_tot <= TOT_W'(r_fcnt)), "trailer count exceeds leftover bits")
    `ASSERT_CLK(a_out_from_engine, i_clk, i_rst_n, $rose(r_o_vld) |-> $past(busy), "output word without engine activity")

endmodule

/* rtl/hcbp_ram.sv */
// ---------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
